[src/sep_pkg.sv]
// Shared types, widths and codes of the sorted edge stream partitioner.
// Depends on nothing; every other file of the block imports it.
package sep_pkg;

  // field and counter widths
  localparam int NODE_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int PART_W     = 11;
  localparam int PNUM_W     = 10;
  localparam int BEYOND_W   = 33;
  localparam int THR_W      = 43;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [PART_W-1:0]  MAX_PARTS = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_EDGES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT  = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EVAL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [PNUM_W-1:0]   part_number;
    logic [NODE_W-1:0]   first_node;
    logic [BEYOND_W-1:0] beyond_node;
    logic [COUNT_W-1:0]  node_total;
    logic [COUNT_W-1:0]  edge_total;
    logic                unsorted_error;
    logic                final_part;
  } result_t;

  // saturating increment of an edge or node count
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // zero-based partition number from the one-based partition index
  function automatic logic [PNUM_W-1:0] part_num(input logic [PART_W-1:0] idx);
    logic [PART_W-1:0] d;
    d = idx - 1'b1;
    return d[PNUM_W-1:0];
  endfunction

endpackage

[src/sep_edge_if.sv]
// Input channel of the partitioner: one edge target id per transfer.
// Depends on sep_pkg for the id width.
interface sep_edge_if;
  import sep_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] target_node;
  logic              stream_end;

  modport source (output valid, output target_node, output stream_end, input ready);
  modport sink (input valid, input target_node, input stream_end, output ready);
endinterface

[src/sep_part_if.sv]
// Output channel of the partitioner: one partition report per transfer.
// Depends on sep_pkg for the field widths.
interface sep_part_if;
  import sep_pkg::*;

  logic                valid;
  logic                ready;
  logic [PNUM_W-1:0]   part_number;
  logic [NODE_W-1:0]   first_node;
  logic [BEYOND_W-1:0] beyond_node;
  logic [COUNT_W-1:0]  node_total;
  logic [COUNT_W-1:0]  edge_total;
  logic                unsorted_error;
  logic                final_part;

  modport source (
    output valid, output part_number, output first_node, output beyond_node,
    output node_total, output edge_total, output unsorted_error, output final_part,
    input ready
  );
  modport sink (
    input valid, input part_number, input first_node, input beyond_node,
    input node_total, input edge_total, input unsorted_error, input final_part,
    output ready
  );
endinterface

[src/sorted_edge_stream_partitioner_top.sv]
// Sorted edge stream partitioner: cuts an ascending stream of edge target ids
// into contiguous, node-aligned partitions of about total_edges/part_count+1
// edges and reports each one. The first edge of a stream waits for the
// bit-serial divider that forms the per-partition quota (32 steps); every edge
// is accepted, then evaluated, and each partition report it causes (at most
// two) is handed to the sink before the next edge is taken. Edges after an
// ordering error are ignored. Configuration writes are registered; total_edges
// is sampled at the start of each stream.
// Depends on sep_pkg, sep_edge_if, sep_part_if and sep_divider.
module sorted_edge_stream_partitioner_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [sep_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [sep_pkg::CFG_DATA_W-1:0] wr_data,
  sep_edge_if.sink                       edges,
  sep_part_if.source                     parts
);
  import sep_pkg::*;

  // configuration
  logic [COUNT_W-1:0] total_edges;
  logic [PART_W-1:0]  part_count;
  logic [PART_W-1:0]  clamped;

  // stream state
  state_t             state;
  state_t             state_next;
  logic [NODE_W-1:0]  current_node;
  logic               node_seen;
  logic [COUNT_W-1:0] edges_so_far;
  logic [COUNT_W-1:0] last_node_start;
  logic [PART_W-1:0]  part_index;
  logic [THR_W-1:0]   cut_threshold;
  logic [COUNT_W-1:0] edges_per_part;
  logic [NODE_W-1:0]  part_first;
  logic [COUNT_W-1:0] part_nodes;
  logic [COUNT_W-1:0] part_edges;
  logic               halted;

  // latched input item
  logic [NODE_W-1:0]  node_in;
  logic               last_in;

  // pending reports
  result_t            res [2];
  logic               res_two;
  logic               res_head;

  // divider hookup
  logic               div_start;
  logic               div_done;
  logic [COUNT_W-1:0] div_quo;
  logic [COUNT_W-1:0] quota;

  logic               in_xfer;
  logic               out_xfer;

  // evaluation results
  logic [NODE_W-1:0]  node_next;
  logic               seen_next;
  logic [COUNT_W-1:0] edges_next;
  logic [COUNT_W-1:0] start_next;
  logic [PART_W-1:0]  pidx_next;
  logic [THR_W-1:0]   thr_next;
  logic [NODE_W-1:0]  first_next;
  logic [COUNT_W-1:0] nodes_next;
  logic [COUNT_W-1:0] pedges_next;
  logic               halted_next;
  logic [1:0]         res_cnt_next;
  result_t            res0_next;
  result_t            res1_next;

  assign in_xfer  = edges.valid && edges.ready;
  assign out_xfer = parts.valid && parts.ready;

  // out-of-range partition counts
  always_comb begin
    if (part_count == '0) begin
      clamped = PART_W'(1);
    end else if (part_count > MAX_PARTS) begin
      clamped = MAX_PARTS;
    end else begin
      clamped = part_count;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      total_edges <= COUNT_W'(1);
      part_count  <= PART_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_TOTAL_EDGES: total_edges <= wr_data[COUNT_W-1:0];
        REG_PART_COUNT:  part_count  <= wr_data[PART_W-1:0];
        default: ;
      endcase
    end
  end

  sep_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_edges),
    .divisor  (clamped),
    .done     (div_done),
    .quotient (div_quo)
  );

  // quota = quotient + 1, saturated
  assign quota = (div_quo == COUNT_MAX) ? COUNT_MAX : div_quo + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer && !halted) begin
          state_next = (edges_so_far == '0) ? S_DIV : S_EVAL;
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = (res_cnt_next == 2'd0) ? S_IDLE : S_OUT;
      end
      S_OUT: begin
        if (out_xfer && (res_head || !res_two)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    edges.ready = (state == S_IDLE);
    parts.valid = (state == S_OUT);
    div_start   = (state == S_IDLE) && edges.valid && !halted && (edges_so_far == '0);
  end

  assign parts.part_number    = res[res_head].part_number;
  assign parts.first_node     = res[res_head].first_node;
  assign parts.beyond_node    = res[res_head].beyond_node;
  assign parts.node_total     = res[res_head].node_total;
  assign parts.edge_total     = res[res_head].edge_total;
  assign parts.unsorted_error = res[res_head].unsorted_error;
  assign parts.final_part     = res[res_head].final_part;

  // one edge against the running counters
  always_comb begin
    logic               new_node;
    logic               order_err;
    logic               cut;
    logic               mid;
    logic [COUNT_W:0]   mid_sum;
    logic [COUNT_W-1:0] moved;
    result_t            fin;

    node_next    = current_node;
    seen_next    = node_seen;
    edges_next   = edges_so_far;
    start_next   = last_node_start;
    pidx_next    = part_index;
    thr_next     = cut_threshold;
    first_next   = part_first;
    nodes_next   = part_nodes;
    pedges_next  = part_edges;
    halted_next  = halted;
    res_cnt_next = 2'd0;
    res0_next    = '0;
    res1_next    = '0;
    fin          = '0;

    new_node  = !node_seen || (current_node != node_in);
    order_err = node_seen && (current_node > node_in);
    cut       = node_seen && ({{(THR_W-COUNT_W){1'b0}}, edges_so_far} >= cut_threshold)
                && (part_index < clamped);
    // previous node's midpoint past the threshold: 2*thr < start + edges
    mid_sum   = {1'b0, last_node_start} + {1'b0, edges_so_far};
    mid       = {cut_threshold, 1'b0} < {{(THR_W-COUNT_W){1'b0}}, mid_sum};
    moved     = (edges_so_far > last_node_start) ? edges_so_far - last_node_start : '0;

    if (new_node && order_err) begin
      // error report, then drop the rest of the stream
      res0_next.part_number    = part_num(part_index);
      res0_next.first_node     = part_first;
      res0_next.unsorted_error = 1'b1;
      res0_next.final_part     = 1'b1;
      res_cnt_next = 2'd1;
      if (last_in) begin
        edges_next = '0;
        seen_next  = 1'b0;
        start_next = '0;
      end else begin
        halted_next = 1'b1;
      end
    end else begin
      if (new_node) begin
        if (cut) begin
          res0_next.part_number = part_num(part_index);
          res0_next.first_node  = part_first;
          if (mid) begin
            // previous node moves into the new partition
            res0_next.beyond_node = {1'b0, current_node};
            res0_next.node_total  = (part_nodes != '0) ? part_nodes - 1'b1 : '0;
            res0_next.edge_total  = (part_edges > moved) ? part_edges - moved : '0;
            first_next  = current_node;
            nodes_next  = COUNT_W'(1);
            pedges_next = moved;
          end else begin
            res0_next.beyond_node = {1'b0, node_in};
            res0_next.node_total  = part_nodes;
            res0_next.edge_total  = part_edges;
            first_next  = node_in;
            nodes_next  = '0;
            pedges_next = '0;
          end
          res_cnt_next = 2'd1;
          pidx_next = part_index + 1'b1;
          thr_next  = cut_threshold + {{(THR_W-COUNT_W){1'b0}}, edges_per_part};
        end
        nodes_next = sat_inc(nodes_next);
        start_next = edges_so_far;
        node_next  = node_in;
        seen_next  = 1'b1;
      end
      pedges_next = sat_inc(pedges_next);
      edges_next  = sat_inc(edges_so_far);

      // last edge closes the final partition
      if (last_in) begin
        fin.part_number = part_num(pidx_next);
        fin.first_node  = first_next;
        fin.beyond_node = {1'b0, node_in} + BEYOND_W'(1);
        fin.node_total  = nodes_next;
        fin.edge_total  = pedges_next;
        fin.final_part  = 1'b1;
        if (res_cnt_next == 2'd0) begin
          res0_next = fin;
        end else begin
          res1_next = fin;
        end
        res_cnt_next = res_cnt_next + 2'd1;
        edges_next   = '0;
        seen_next    = 1'b0;
        start_next   = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      current_node    <= '0;
      node_seen       <= 1'b0;
      edges_so_far    <= '0;
      last_node_start <= '0;
      part_index      <= PART_W'(1);
      cut_threshold   <= '0;
      edges_per_part  <= '0;
      part_first      <= '0;
      part_nodes      <= '0;
      part_edges      <= '0;
      halted          <= 1'b0;
      res_two         <= 1'b0;
      res_head        <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          // an ignored stream ends on its last edge
          if (in_xfer && halted && edges.stream_end) begin
            edges_so_far    <= '0;
            node_seen       <= 1'b0;
            last_node_start <= '0;
            halted          <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            edges_per_part <= quota;
            cut_threshold  <= {{(THR_W-COUNT_W){1'b0}}, quota};
            part_index     <= PART_W'(1);
            part_first     <= node_in;
            part_nodes     <= '0;
            part_edges     <= '0;
          end
        end
        S_EVAL: begin
          current_node    <= node_next;
          node_seen       <= seen_next;
          edges_so_far    <= edges_next;
          last_node_start <= start_next;
          part_index      <= pidx_next;
          cut_threshold   <= thr_next;
          part_first      <= first_next;
          part_nodes      <= nodes_next;
          part_edges      <= pedges_next;
          halted          <= halted_next;
          res_two         <= (res_cnt_next == 2'd2);
          res_head        <= 1'b0;
        end
        S_OUT: begin
          if (out_xfer) res_head <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // input item and report registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      node_in <= edges.target_node;
      last_in <= edges.stream_end;
    end
    if (state == S_EVAL) begin
      res[0] <= res0_next;
      res[1] <= res1_next;
    end
  end

  a_err_is_final: assert property (@(posedge clk) disable iff (rst)
    parts.valid && parts.unsorted_error |-> parts.final_part)
    else $error("error report not marked as final");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    edges.ready |-> !parts.valid)
    else $error("input taken while a report is pending");
  a_part_index_range: assert property (@(posedge clk) disable iff (rst)
    part_index != '0 && part_index <= MAX_PARTS)
    else $error("partition index out of range");
  a_halt_needs_node: assert property (@(posedge clk) disable iff (rst)
    halted |-> node_seen)
    else $error("stream halted without a previous node");

endmodule

[src/sep_divider.sv]
// Restoring divider, one quotient bit per cycle: edge count over partition count.
// Depends on sep_pkg for the widths.
module sep_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sep_pkg::COUNT_W-1:0] dividend,
  input  logic [sep_pkg::PART_W-1:0]  divisor,
  output logic                        done,
  output logic [sep_pkg::COUNT_W-1:0] quotient
);
  import sep_pkg::*;

  localparam int STEP_W = $clog2(COUNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COUNT_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [PART_W-1:0] rem;
  logic [PART_W-1:0] dvs;
  logic [COUNT_W-1:0] quo;
  logic [PART_W:0]   trial;
  logic [PART_W:0]   diff;
  logic              fits;

  // one trial subtract per cycle
  assign trial = {rem, quo[COUNT_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = quo;

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[PART_W-1:0] : trial[PART_W-1:0];
      quo <= {quo[COUNT_W-2:0], fits};
    end
  end

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    busy && !start && step == LAST_STEP |=> done && !busy)
    else $error("divider did not finish after its last step");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider reports done while still busy");
  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

[dv/tb_sorted_edge_stream_partitioner_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the sorted edge stream partitioner: random and directed
// edge streams, a transfer-level predictor and a field-by-field report checker.
// Depends on sep_pkg, sep_edge_if, sep_part_if and the partitioner RTL.
module tb_sorted_edge_stream_partitioner_top;
  import sep_pkg::*;

  localparam int unsigned EDGE_BUDGET   = 1850;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned STALL_LIMIT   = 3000;

  typedef struct packed {
    logic [NODE_W-1:0] id;
    logic              last;
  } edge_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  sep_edge_if edges_ch ();
  sep_part_if parts_ch ();

  sorted_edge_stream_partitioner_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .edges    (edges_ch),
    .parts    (parts_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bench bookkeeping
  edge_item_t  edge_backlog[$];
  result_t     part_reports_due[$];
  edge_item_t  next_edge;
  int unsigned edges_queued   = 0;
  int unsigned edges_accepted = 0;
  int unsigned dropped_edges  = 0;
  int unsigned reports_seen   = 0;
  int unsigned fail_count     = 0;
  int unsigned config_phases  = 0;
  int unsigned quiet_cycles   = 0;

  // predictor copy of the registers and the partition state
  logic [COUNT_W-1:0] cfg_total;
  logic [PART_W-1:0]  cfg_parts;
  logic [NODE_W-1:0]  cur_node;
  logic               node_open;
  logic [COUNT_W-1:0] seen_edges;
  logic [COUNT_W-1:0] node_start;
  logic [PART_W-1:0]  part_idx;
  logic [63:0]        next_cut;
  logic [COUNT_W-1:0] quota;
  logic [NODE_W-1:0]  first_id;
  logic [COUNT_W-1:0] nodes_in;
  logic [COUNT_W-1:0] edges_in;
  logic               skip_rest;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [PART_W-1:0] eff_parts();
    if (cfg_parts == '0) return 11'd1;
    if (cfg_parts > MAX_PARTS) return MAX_PARTS;
    return cfg_parts;
  endfunction

  function automatic void close_stream();
    seen_edges = '0;
    node_open  = 1'b0;
    node_start = '0;
    skip_rest  = 1'b0;
  endfunction

  function automatic void report(input logic [NODE_W-1:0] first,
                                 input logic [BEYOND_W-1:0] beyond,
                                 input logic [COUNT_W-1:0] node_cnt,
                                 input logic [COUNT_W-1:0] edge_cnt,
                                 input logic err, input logic fin);
    result_t r;
    logic [PART_W-1:0] pn;
    pn = part_idx - 1'b1;
    r.part_number    = pn[PNUM_W-1:0];
    r.first_node     = first;
    r.beyond_node    = beyond;
    r.node_total     = node_cnt;
    r.edge_total     = edge_cnt;
    r.unsorted_error = err;
    r.final_part     = fin;
    part_reports_due.push_back(r);
  endfunction

  // advance the partition state by one accepted edge, queue the reports it causes
  task automatic partition_step(input logic [NODE_W-1:0] id, input logic last);
    logic [63:0]        q;
    logic [64:0]        cut_sum;
    logic [COUNT_W-1:0] moved;
    if (skip_rest) begin
      if (last) close_stream();
      return;
    end
    // quota is formed on the first edge of a stream
    if (seen_edges == '0) begin
      q = {32'd0, cfg_total} / {53'd0, eff_parts()} + 64'd1;
      quota     = (q > 64'hFFFF_FFFF) ? '1 : q[COUNT_W-1:0];
      next_cut  = {32'd0, quota};
      part_idx  = 11'd1;
      first_id  = id;
      nodes_in  = '0;
      edges_in  = '0;
    end
    if (!node_open || cur_node != id) begin
      // descending id: one error report, then drop the rest of the stream
      if (node_open && cur_node > id) begin
        report(first_id, '0, '0, '0, 1'b1, 1'b1);
        if (last) close_stream();
        else skip_rest = 1'b1;
        return;
      end
      if (node_open && {32'd0, seen_edges} >= next_cut && part_idx < eff_parts()) begin
        if ({next_cut, 1'b0} < ({33'd0, node_start} + {33'd0, seen_edges})) begin
          // previous node straddles the cut: it opens the next partition
          moved = (seen_edges > node_start) ? seen_edges - node_start : '0;
          report(first_id, {1'b0, cur_node}, (nodes_in != '0) ? nodes_in - 1'b1 : '0,
                 (edges_in > moved) ? edges_in - moved : '0, 1'b0, 1'b0);
          first_id = cur_node;
          nodes_in = 32'd1;
          edges_in = moved;
        end else begin
          report(first_id, {1'b0, id}, nodes_in, edges_in, 1'b0, 1'b0);
          first_id = id;
          nodes_in = '0;
          edges_in = '0;
        end
        part_idx++;
        cut_sum  = {1'b0, next_cut} + {33'd0, quota};
        next_cut = cut_sum[64] ? '1 : cut_sum[63:0];
      end
      nodes_in   = bump(nodes_in);
      node_start = seen_edges;
      cur_node   = id;
      node_open  = 1'b1;
    end
    edges_in   = bump(edges_in);
    seen_edges = bump(seen_edges);
    if (last) begin
      report(first_id, {1'b0, id} + 33'd1, nodes_in, edges_in, 1'b0, 1'b1);
      close_stream();
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // edge driver: offers the backlog with random gaps, predicts on each transfer
  int unsigned gap_left = 0;
  bit          src_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      edges_ch.valid <= 1'b0;
    end else begin
      if (edges_ch.valid && edges_ch.ready) begin
        partition_step(edges_ch.target_node, edges_ch.stream_end);
        edges_accepted++;
      end
      if ($urandom_range(0, 199) == 0) src_calm = !src_calm;
      if (!edges_ch.valid || edges_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          edges_ch.valid <= 1'b0;
        end else if (edge_backlog.size() != 0) begin
          next_edge = edge_backlog.pop_front();
          edges_ch.target_node <= next_edge.id;
          edges_ch.stream_end  <= next_edge.last;
          edges_ch.valid       <= 1'b1;
          gap_left = src_calm ? 0 : pick_gap();
        end else begin
          edges_ch.valid <= 1'b0;
        end
      end
    end
  end

  // report monitor: random backpressure, up to two long holds, compares each transfer
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned holds_done = 0;
  int unsigned hold_mark  = 20;
  bit          sink_calm  = 1'b0;
  result_t     due;
  always @(posedge clk) begin
    if (rst) begin
      parts_ch.ready <= 1'b0;
    end else begin
      if (parts_ch.valid && parts_ch.ready) begin
        reports_seen++;
        if (part_reports_due.size() == 0) begin
          $error("partition report %0d arrived with none pending", parts_ch.part_number);
          fail_count++;
        end else begin
          due = part_reports_due.pop_front();
          check_field("part_number", 64'(due.part_number), 64'(parts_ch.part_number));
          check_field("first_node", 64'(due.first_node), 64'(parts_ch.first_node));
          check_field("beyond_node", 64'(due.beyond_node), 64'(parts_ch.beyond_node));
          check_field("node_total", 64'(due.node_total), 64'(parts_ch.node_total));
          check_field("edge_total", 64'(due.edge_total), 64'(parts_ch.edge_total));
          check_field("unsorted_error", 64'(due.unsorted_error),
                      64'(parts_ch.unsorted_error));
          check_field("final_part", 64'(due.final_part), 64'(parts_ch.final_part));
        end
      end
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      if (hold_left != 0) begin
        hold_left--;
        parts_ch.ready <= 1'b0;
      end else if (holds_done < 2 && reports_seen >= hold_mark && edge_backlog.size() > 30) begin
        // long hold while the driver keeps offering, so the block backs up
        hold_left = LONG_HOLD - 1;
        holds_done++;
        hold_mark = 500;
        parts_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        parts_ch.ready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
        parts_ch.ready <= 1'b0;
      end else begin
        parts_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (edges_ch.valid && edges_ch.ready) || (parts_ch.valid && parts_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_sorted_edge_stream_partitioner_top NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      REG_TOTAL_EDGES: cfg_total = data;
      REG_PART_COUNT:  cfg_parts = data[PART_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_config(input logic [COUNT_W-1:0] total, input logic [PART_W-1:0] parts);
    write_reg(REG_TOTAL_EDGES, total);
    write_reg(REG_PART_COUNT, {{(CFG_DATA_W - PART_W){1'b0}}, parts});
    config_phases++;
  endtask

  task automatic push_edge(input logic [NODE_W-1:0] id, input logic last);
    edge_backlog.push_back('{id, last});
    edges_queued++;
  endtask

  // wait until every edge is taken and every report has come, then let it settle
  task automatic drain();
    while (edges_accepted != edges_queued || part_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one ascending stream; a faulty one carries a lower id and some dropped tail
  task automatic add_stream(input int unsigned len, input bit fault);
    logic [32:0]       id;
    logic [NODE_W-1:0] prev;
    logic [NODE_W-1:0] bad;
    int unsigned       sent;
    int unsigned       mult;
    int unsigned       bad_at;
    int unsigned       junk;
    int unsigned       r;
    r = $urandom_range(0, 19);
    if (r < 14) id = {1'b0, $urandom_range(1, 2000)};
    else if (r < 17) id = {1'b0, $urandom()};
    else id = 33'h0_FFFF_FFFF - $urandom_range(0, 60);
    if (id == '0) id = 33'd1;
    prev   = id[NODE_W-1:0];
    bad_at = fault ? $urandom_range(1, len - 1) : len;
    sent   = 0;
    while (sent < bad_at) begin
      r = $urandom_range(0, 99);
      mult = (r < 60) ? 1 : (r < 90) ? $urandom_range(2, 4) : $urandom_range(5, 20);
      for (int k = 0; k < mult && sent < bad_at; k++) begin
        push_edge(id[NODE_W-1:0], !fault && sent == len - 1);
        prev = id[NODE_W-1:0];
        sent++;
      end
      r = $urandom_range(0, 99);
      id = id + 33'((r < 70) ? 1 : (r < 95) ? $urandom_range(2, 9) : $urandom_range(10, 100000));
      if (id > 33'h0_FFFF_FFFF) id = 33'h0_FFFF_FFFF;
    end
    if (fault) begin
      bad  = prev - 1'b1 - ($urandom() % prev);
      junk = $urandom_range(0, 4);
      push_edge(bad, junk == 0);
      for (int k = 0; k < junk; k++) push_edge($urandom(), k == junk - 1);
      dropped_edges += junk;
    end
  endtask

  initial begin
    int unsigned       r;
    int unsigned       mean_len;
    logic [COUNT_W-1:0] total;
    logic [PART_W-1:0]  parts;
    // known levels on every input from time zero
    wr_en = 1'b0;
    wr_index = REG_TOTAL_EDGES;
    wr_data = '0;
    edges_ch.valid = 1'b0;
    edges_ch.target_node = '0;
    edges_ch.stream_end = 1'b0;
    parts_ch.ready = 1'b0;
    cfg_total = 32'd1;
    cfg_parts = 11'd1;
    cur_node = '0;
    part_idx = 11'd1;
    next_cut = '0;
    quota = '0;
    first_id = '0;
    nodes_in = '0;
    edges_in = '0;
    close_stream();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero total and zero part count: quota of one, a single partition
    set_config(32'd0, 11'd0);
    push_edge(32'd5, 1'b0);
    push_edge(32'd5, 1'b0);
    push_edge(32'd6, 1'b0);
    push_edge(32'd9, 1'b1);
    drain();

    // quota 3: heavy first node moves alone (empty partition), cut and end together
    set_config(32'd8, 11'd4);
    repeat (7) push_edge(32'd10, 1'b0);
    push_edge(32'd11, 1'b0);
    push_edge(32'd12, 1'b0);
    push_edge(32'd13, 1'b1);
    // ordering fault on the closing edge, then one with a dropped tail
    push_edge(32'd20, 1'b0);
    push_edge(32'd21, 1'b0);
    push_edge(32'd19, 1'b1);
    push_edge(32'd30, 1'b0);
    push_edge(32'd31, 1'b0);
    push_edge(32'd2, 1'b0);
    push_edge(32'd7, 1'b0);
    push_edge(32'd40, 1'b1);
    dropped_edges += 2;
    drain();

    // largest total over one partition: the quota saturates
    set_config(32'hFFFF_FFFF, 11'd1);
    push_edge(32'd3, 1'b0);
    push_edge(32'd3, 1'b0);
    push_edge(32'd4, 1'b1);
    drain();

    // large quota, oversized part count, top id carries into the wide beyond
    set_config(32'hFFFF_FFFF, 11'h7FF);
    push_edge(32'hFFFF_FFFE, 1'b0);
    push_edge(32'hFFFF_FFFF, 1'b0);
    push_edge(32'hFFFF_FFFF, 1'b1);
    drain();

    // random phases: new registers, a few streams, full drain between them
    while (edges_queued - dropped_edges < EDGE_BUDGET) begin
      r = $urandom_range(0, 19);
      if (r < 12) parts = PART_W'($urandom_range(1, 8));
      else if (r < 15) parts = PART_W'($urandom_range(9, 64));
      else if (r == 15) parts = 11'd1;
      else if (r == 16) parts = MAX_PARTS;
      else if (r == 17) parts = 11'd0;
      else if (r == 18) parts = PART_W'($urandom_range(1025, 2047));
      else parts = PART_W'($urandom_range(65, 1023));
      mean_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(3, 30);
      r = $urandom_range(0, 19);
      if (r < 16) total = $urandom_range(mean_len / 2 + 1, mean_len * 2);
      else if (r == 16) total = '0;
      else if (r == 17) total = '1;
      else total = $urandom();
      set_config(total, parts);
      repeat ($urandom_range(2, 6))
        add_stream($urandom_range(mean_len / 2 + 2, mean_len + mean_len / 2 + 2),
                   $urandom_range(0, 9) == 0);
      drain();
    end

    $display("Run covered %0d edges (%0d dropped after ordering faults) over %0d settings,",
             edges_accepted, dropped_edges, config_phases);
    $display("with %0d partition reports compared and %0d long sink holds.",
             reports_seen, holds_done);
    if (fail_count == 0 && part_reports_due.size() == 0) begin
      $display("tb_sorted_edge_stream_partitioner_top OK");
    end else begin
      $display("tb_sorted_edge_stream_partitioner_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
src/sep_pkg.sv
src/sep_edge_if.sv
src/sep_part_if.sv
src/sep_divider.sv
src/sorted_edge_stream_partitioner_top.sv
dv/tb_sorted_edge_stream_partitioner_top.sv
